@@ hw/rtl/pgm_pkg.sv @@
// Shared types and constants for the PGM (P5) byte-stream parser.
// No dependencies; used by pgm_core and pgm_p5_stream_to_pixels_top.
`timescale 1ns / 1ps
`default_nettype none

package pgm_pkg;

  // Default coordinate counter width
  localparam int COORD_BITS_DEFAULT = 12;

  // Port widths fixed by the stream format
  localparam int DISP_W    = 12;
  localparam int PIX_W     = 12;
  localparam int LEVEL_W   = 3;
  localparam int STATUS_W  = 3;
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_HEIGHT = 1'd1;

  localparam logic [DISP_W-1:0] DISPLAY_WIDTH_RST  = 12'd800;
  localparam logic [DISP_W-1:0] DISPLAY_HEIGHT_RST = 12'd600;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_HEADER     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PIXELS     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_MAGIC  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_NUMBER = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_MAXVAL = 3'd4;

  // One result per input byte
  typedef struct packed {
    logic [STATUS_W-1:0] parse_status;
    logic [LEVEL_W-1:0]  pixel_level;
    logic [PIX_W-1:0]    pixel_y;
    logic [PIX_W-1:0]    pixel_x;
    logic                pixel_valid;
  } pixel_result_t;

endpackage

`default_nettype wire

@@ hw/rtl/pgm_core.sv @@
// Parser state and per-byte next-state logic for the PGM (P5) stream.
// Depends on pgm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pgm_core #(
  parameter int COORD_BITS = pgm_pkg::COORD_BITS_DEFAULT
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              step,
  input  wire [pgm_pkg::BYTE_W-1:0]        data_byte,
  input  wire                              frame_start,
  input  wire [pgm_pkg::DISP_W-1:0]        display_width,
  input  wire [pgm_pkg::DISP_W-1:0]        display_height,
  output pgm_pkg::pixel_result_t           result
);

  localparam int ACC_W  = COORD_BITS + 1;
  localparam int PROD_W = ACC_W + 4;
  localparam int CMP_W  = (COORD_BITS > pgm_pkg::DISP_W) ? COORD_BITS : pgm_pkg::DISP_W;
  localparam logic [ACC_W-1:0] ACC_LIMIT = {1'b1, {COORD_BITS{1'b0}}};
  localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

  localparam logic [3:0] PH_MAGIC_P    = 4'd0;
  localparam logic [3:0] PH_MAGIC_5    = 4'd1;
  localparam logic [3:0] PH_WIDTH      = 4'd2;
  localparam logic [3:0] PH_HEIGHT     = 4'd3;
  localparam logic [3:0] PH_MAXVAL     = 4'd4;
  localparam logic [3:0] PH_PIXELS     = 4'd5;
  localparam logic [3:0] PH_BAD_MAGIC  = 4'd6;
  localparam logic [3:0] PH_BAD_NUMBER = 4'd7;
  localparam logic [3:0] PH_BAD_MAXVAL = 4'd8;

  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_5     = 8'h35;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [ACC_W-1:0] MAXVAL_OK = ACC_W'(255);
  localparam int LEVEL_SHIFT = 5;

  logic [3:0]            phase, phase_next;
  logic                  in_comment, in_comment_next;
  logic                  digit_seen, digit_seen_next;
  logic [ACC_W-1:0]      number_acc, number_acc_next;
  logic [COORD_BITS-1:0] image_width, image_width_next;
  logic [COORD_BITS-1:0] col_count, col_count_next;
  logic [COORD_BITS-1:0] row_count, row_count_next;

  logic [3:0]            ph;
  logic                  cmt, seen;
  logic [ACC_W-1:0]      acc;
  logic [PROD_W-1:0]     acc_prod;
  logic [COORD_BITS-1:0] col_inc;
  logic                  is_digit, is_space, in_disp;

  always_comb begin
    // frame_start clears the parser before this byte is looked at
    ph   = frame_start ? PH_MAGIC_P : phase;
    cmt  = frame_start ? 1'b0 : in_comment;
    seen = frame_start ? 1'b0 : digit_seen;
    acc  = frame_start ? '0 : number_acc;

    phase_next       = ph;
    in_comment_next  = cmt;
    digit_seen_next  = seen;
    number_acc_next  = acc;
    image_width_next = frame_start ? '0 : image_width;
    col_count_next   = frame_start ? '0 : col_count;
    row_count_next   = frame_start ? '0 : row_count;

    is_digit = (data_byte >= CHAR_0) && (data_byte <= CHAR_9);
    is_space = (data_byte == CHAR_SPACE) || ((data_byte >= CHAR_TAB) && (data_byte <= CHAR_CR));
    acc_prod = (PROD_W'(acc) << 3) + (PROD_W'(acc) << 1) + PROD_W'(data_byte[3:0]);
    col_inc  = col_count_next + 1'b1;
    in_disp  = (CMP_W'(col_count_next) < CMP_W'(display_width)) &&
               (CMP_W'(row_count_next) < CMP_W'(display_height));

    result = '0;

    case (ph)
      PH_MAGIC_P: begin
        phase_next = (data_byte == CHAR_P) ? PH_MAGIC_5 : PH_BAD_MAGIC;
      end
      PH_MAGIC_5: begin
        phase_next = (data_byte == CHAR_5) ? PH_WIDTH : PH_BAD_MAGIC;
      end
      PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
        if (cmt) begin
          if (data_byte == CHAR_LF) in_comment_next = 1'b0;
        end else if (is_digit) begin
          number_acc_next = (acc_prod > PROD_W'(ACC_LIMIT)) ? ACC_LIMIT : acc_prod[ACC_W-1:0];
          digit_seen_next = 1'b1;
        end else if (is_space) begin
          if (seen) begin
            // close out the pending number
            number_acc_next = '0;
            digit_seen_next = 1'b0;
            if (ph == PH_MAXVAL) begin
              if (acc == '0)            phase_next = PH_BAD_NUMBER;
              else if (acc != MAXVAL_OK) phase_next = PH_BAD_MAXVAL;
              else                       phase_next = PH_PIXELS;
            end else if ((acc == '0) || acc[COORD_BITS]) begin
              phase_next = PH_BAD_NUMBER;
            end else if (ph == PH_WIDTH) begin
              image_width_next = acc[COORD_BITS-1:0];
              phase_next       = PH_HEIGHT;
            end else begin
              phase_next = PH_MAXVAL;
            end
          end
        end else if ((data_byte == CHAR_HASH) && !seen) begin
          in_comment_next = 1'b1;
        end else begin
          phase_next = PH_BAD_NUMBER;
        end
      end
      PH_PIXELS: begin
        if (in_disp) begin
          result.pixel_valid = 1'b1;
          result.pixel_x     = pgm_pkg::PIX_W'(col_count_next);
          result.pixel_y     = pgm_pkg::PIX_W'(row_count_next);
          result.pixel_level = data_byte[pgm_pkg::BYTE_W-1:LEVEL_SHIFT];
        end
        // wrap the column at image width, saturate the row
        if (col_inc >= image_width_next) begin
          col_count_next = '0;
          if (row_count_next != COORD_MAX) row_count_next = row_count_next + 1'b1;
        end else begin
          col_count_next = col_inc;
        end
      end
      default: ;
    endcase

    case (phase_next)
      PH_PIXELS:     result.parse_status = pgm_pkg::ST_PIXELS;
      PH_BAD_MAGIC:  result.parse_status = pgm_pkg::ST_BAD_MAGIC;
      PH_BAD_NUMBER: result.parse_status = pgm_pkg::ST_BAD_NUMBER;
      PH_BAD_MAXVAL: result.parse_status = pgm_pkg::ST_BAD_MAXVAL;
      default:       result.parse_status = pgm_pkg::ST_HEADER;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_MAGIC_P;
      in_comment  <= 1'b0;
      digit_seen  <= 1'b0;
      number_acc  <= '0;
      image_width <= '0;
      col_count   <= '0;
      row_count   <= '0;
    end else if (step) begin
      phase       <= phase_next;
      in_comment  <= in_comment_next;
      digit_seen  <= digit_seen_next;
      number_acc  <= number_acc_next;
      image_width <= image_width_next;
      col_count   <= col_count_next;
      row_count   <= row_count_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pgm_p5_stream_to_pixels_top.sv @@
// Top level of the PGM (P5) stream to 3-bit pixel converter: input register,
// display config registers, output register. Depends on pgm_pkg, pgm_core.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------------
//   s_*      | s_tvalid / s_tready       | tdata: data_byte; tuser: frame_start
//   m_*      | m_tvalid / m_tready       | tdata: valid, x, y, level, status
//   cfg_*    | cfg_we                    | cfg_index, cfg_wdata
//
// One byte per cycle sustained while m_tready stays high; each byte passes the
// input register, then the parser step into the output register. The parser
// state loop closes on every step, so back-to-back transfers run at full rate.
// rst is synchronous and clears the parser and both stages; display size
// returns to 800 x 600. A stalled output holds its result; input is still
// taken while the input register drains into a free output register.
`timescale 1ns / 1ps
`default_nettype none

module pgm_p5_stream_to_pixels_top #(
  parameter int COORD_BITS = pgm_pkg::COORD_BITS_DEFAULT
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              s_tvalid,
  output logic                             s_tready,
  input  wire  [7:0]                       s_tdata,   // [7:0] data_byte
  input  wire  [0:0]                       s_tuser,   // [0] frame_start
  output logic                             m_tvalid,
  input  wire                              m_tready,
  // [0] pixel_valid, [12:1] pixel_x, [24:13] pixel_y, [27:25] pixel_level,
  // [30:28] parse_status, [31] zero
  output logic [31:0]                      m_tdata,
  input  wire                              cfg_we,
  input  wire  [pgm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [pgm_pkg::DISP_W-1:0]       cfg_wdata
);

  logic                           in_valid;
  logic [pgm_pkg::BYTE_W-1:0]     in_byte;
  logic                           in_start;
  logic                           out_valid;
  pgm_pkg::pixel_result_t         out_data;
  pgm_pkg::pixel_result_t         step_result;
  logic [pgm_pkg::DISP_W-1:0]     display_width;
  logic [pgm_pkg::DISP_W-1:0]     display_height;
  logic                           advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      display_width  <= pgm_pkg::DISPLAY_WIDTH_RST;
      display_height <= pgm_pkg::DISPLAY_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pgm_pkg::CFG_DISPLAY_WIDTH:  display_width  <= cfg_wdata;
        pgm_pkg::CFG_DISPLAY_HEIGHT: display_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input stage: hold the byte until the parser steps on it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_byte  <= '0;
      in_start <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
      if (s_tvalid) begin
        in_byte  <= s_tdata;
        in_start <= s_tuser[0];
      end
    end
  end

  pgm_core #(
    .COORD_BITS(COORD_BITS)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .data_byte      (in_byte),
    .frame_start    (in_start),
    .display_width  (display_width),
    .display_height (display_height),
    .result         (step_result)
  );

  // output stage: hold the result until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_data  <= '0;
    end else if (advance) begin
      out_valid <= 1'b1;
      out_data  <= step_result;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ tb/pgm_pixel_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for pgm_p5_stream_to_pixels_top: predicts one pixel result per
// byte transfer and checks the result stream in order. Depends on pgm_pkg.
module pgm_pixel_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] data_byte
  input  logic [0:0]                    s_tuser,   // [0] frame_start
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  // [0] pixel_valid, [12:1] pixel_x, [24:13] pixel_y, [27:25] pixel_level,
  // [30:28] parse_status, [31] zero
  input  logic [31:0]                   m_tdata,
  input  logic                          cfg_we,
  input  logic [pgm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pgm_pkg::DISP_W-1:0]    cfg_wdata,
  output int                            mismatches,
  output int                            pending
);

  localparam int COORD_W = pgm_pkg::COORD_BITS_DEFAULT;
  localparam int ACC_W = COORD_W + 1;
  localparam int COORD_MAX = (1 << COORD_W) - 1;
  localparam int MAX_REPORTS = 10;
  localparam int FULL_MAXVAL = 255;
  localparam logic [7:0] LINE_FEED = 8'd10;
  localparam logic [7:0] CTRL_BLANK_LO = 8'd9;
  localparam logic [7:0] CTRL_BLANK_HI = 8'd13;

  typedef enum logic [3:0] {
    SEEK_P, SEEK_5, GET_WIDTH, GET_HEIGHT, GET_MAXVAL, IN_PIXELS,
    ERR_MAGIC, ERR_NUMBER, ERR_MAXVAL
  } parse_phase_e;

  logic [pgm_pkg::DISP_W-1:0]    disp_w, disp_h;
  parse_phase_e                  phase;
  logic                          in_comment, digit_seen;
  logic [ACC_W-1:0]              acc;
  logic [COORD_W-1:0]            img_w, col, row;
  pgm_pkg::pixel_result_t        expected_pixels[$];
  int                            bad_results = 0;

  assign mismatches = bad_results;

  function automatic void clear_parser();
    phase = SEEK_P;
    in_comment = 1'b0;
    digit_seen = 1'b0;
    acc = '0;
    img_w = '0;
    col = '0;
    row = '0;
  endfunction

  // A whitespace byte after digits closes the current header number.
  function automatic void close_number();
    int unsigned v;
    v = 32'(acc);
    acc = '0;
    digit_seen = 1'b0;
    if (phase == GET_MAXVAL) begin
      if (v == 0) phase = ERR_NUMBER;
      else if (v != FULL_MAXVAL) phase = ERR_MAXVAL;
      else phase = IN_PIXELS;
    end else if (v == 0 || v > COORD_MAX) begin
      phase = ERR_NUMBER;
    end else if (phase == GET_WIDTH) begin
      img_w = COORD_W'(v);
      phase = GET_HEIGHT;
    end else begin
      phase = GET_MAXVAL;
    end
  endfunction

  function automatic pgm_pkg::pixel_result_t parse_pgm_byte(input logic [7:0] b,
                                                            input logic fs);
    pgm_pkg::pixel_result_t r;
    int unsigned n;
    r = '0;
    if (fs) clear_parser();
    case (phase)
      SEEK_P: begin
        if (b == "P") phase = SEEK_5;
        else phase = ERR_MAGIC;
      end
      SEEK_5: begin
        if (b == "5") phase = GET_WIDTH;
        else phase = ERR_MAGIC;
      end
      GET_WIDTH, GET_HEIGHT, GET_MAXVAL: begin
        if (in_comment) begin
          if (b == LINE_FEED) in_comment = 1'b0;
        end else if (b >= "0" && b <= "9") begin
          n = acc * 10 + (b - "0");
          acc = ACC_W'((n > COORD_MAX + 1) ? COORD_MAX + 1 : n);
          digit_seen = 1'b1;
        end else if (b == " " || (b >= CTRL_BLANK_LO && b <= CTRL_BLANK_HI)) begin
          if (digit_seen) close_number();
        end else if (b == "#" && !digit_seen) begin
          in_comment = 1'b1;
        end else begin
          phase = ERR_NUMBER;
        end
      end
      IN_PIXELS: begin
        if (col < disp_w && row < disp_h) begin
          r.pixel_valid = 1'b1;
          r.pixel_x = col;
          r.pixel_y = row;
          r.pixel_level = b[7:5];
        end
        col = col + 1'b1;
        if (col >= img_w) begin
          col = '0;
          if (row != COORD_MAX) row = row + 1'b1;
        end
      end
      default: ;
    endcase
    case (phase)
      IN_PIXELS:  r.parse_status = pgm_pkg::ST_PIXELS;
      ERR_MAGIC:  r.parse_status = pgm_pkg::ST_BAD_MAGIC;
      ERR_NUMBER: r.parse_status = pgm_pkg::ST_BAD_NUMBER;
      ERR_MAXVAL: r.parse_status = pgm_pkg::ST_BAD_MAXVAL;
      default:    r.parse_status = pgm_pkg::ST_HEADER;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    pgm_pkg::pixel_result_t got, want;
    if (rst) begin
      disp_w = pgm_pkg::DISPLAY_WIDTH_RST;
      disp_h = pgm_pkg::DISPLAY_HEIGHT_RST;
      clear_parser();
      expected_pixels.delete();
    end else begin
      // retire before predicting: a byte taken at this edge cannot be out yet
      if (m_tvalid && m_tready) begin
        got = pgm_pkg::pixel_result_t'(m_tdata[30:0]);
        if (expected_pixels.size() == 0) begin
          bad_results++;
          if (bad_results <= MAX_REPORTS)
            $display("%0t: pixel result 0x%h with no byte outstanding", $realtime, m_tdata);
        end else begin
          want = expected_pixels.pop_front();
          if (got.pixel_valid !== want.pixel_valid || got.pixel_x !== want.pixel_x ||
              got.pixel_y !== want.pixel_y || got.pixel_level !== want.pixel_level ||
              got.parse_status !== want.parse_status) begin
            bad_results++;
            if (bad_results <= MAX_REPORTS)
              $display({"%0t: pixel mismatch exp v=%0b x=%0d y=%0d lvl=%0d st=%0d,",
                        " got v=%0b x=%0d y=%0d lvl=%0d st=%0d"},
                       $realtime, want.pixel_valid, want.pixel_x, want.pixel_y,
                       want.pixel_level, want.parse_status, got.pixel_valid, got.pixel_x,
                       got.pixel_y, got.pixel_level, got.parse_status);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          pgm_pkg::CFG_DISPLAY_WIDTH:  disp_w = cfg_wdata;
          pgm_pkg::CFG_DISPLAY_HEIGHT: disp_h = cfg_wdata;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        expected_pixels.push_back(parse_pgm_byte(s_tdata, s_tuser[0]));
    end
    pending <= expected_pixels.size();
  end

endmodule

@@ tb/tb_pgm_p5_stream_to_pixels_top.sv @@
`timescale 1ns / 1ps
// Testbench top for pgm_p5_stream_to_pixels_top: clock, reset, PGM byte streams
// and display settings. Depends on pgm_pkg and pgm_pixel_checker.
module tb_pgm_p5_stream_to_pixels_top;

  localparam int COORD_MAX = (1 << pgm_pkg::COORD_BITS_DEFAULT) - 1;
  localparam int DISP_BITS = pgm_pkg::DISP_W;
  localparam int ITEM_TARGET = 1300;
  localparam int SETTING_PHASES = 4;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int LONG_HOLD = 400;
  localparam int SETTLE_CYCLES = 6;
  localparam int FULL_MAXVAL = 255;
  localparam int COLUMN_ROWS = 64;
  localparam logic [7:0] LINE_FEED = 8'd10;
  localparam logic [7:0] CTRL_BLANK_LO = 8'd9;
  localparam logic [7:0] CTRL_BLANK_HI = 8'd13;

  typedef enum int {
    F_NONE, F_MAGIC_P, F_MAGIC_5, F_WIDTH_ZERO, F_WIDTH_BIG, F_HEIGHT_ZERO,
    F_HEIGHT_BIG, F_MAXVAL_ZERO, F_MAXVAL_ODD, F_HASH_IN_NUMBER, F_BAD_CHAR, F_NOISE
  } frame_fault_e;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [7:0]                    s_tdata = '0;     // [7:0] data_byte
  logic [0:0]                    s_tuser = '0;     // [0] frame_start
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  // [0] pixel_valid, [12:1] pixel_x, [24:13] pixel_y, [27:25] pixel_level,
  // [30:28] parse_status, [31] zero
  logic [31:0]                   m_tdata;
  logic                          cfg_we = 1'b0;
  logic [pgm_pkg::CFG_IDX_W-1:0] cfg_index = pgm_pkg::CFG_DISPLAY_WIDTH;
  logic [pgm_pkg::DISP_W-1:0]    cfg_wdata = '0;

  int   mismatches, pending;
  int   cycles = 0;
  bit   src_gaps = 1'b1;
  bit   sink_stalls = 1'b1;
  int   hold_left = 0;
  int   items_done = 0;
  logic [7:0] frame_bytes[$];

  always #6 clk = ~clk;

  pgm_p5_stream_to_pixels_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  pgm_pixel_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("pgm_p5_stream_to_pixels_top verification failed");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(12, 60);
    return $urandom_range(1, 3);
  endfunction

  initial begin : sink
    int n;
    forever begin
      if (hold_left > 0) begin
        n = hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fs);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= fs;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    gap = (src_gaps && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // noisy: frame_start lands on random bytes instead of the first one
  task automatic send_frame(input bit noisy);
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], noisy ? ($urandom_range(0, 7) == 0) : (i == 0));
  endtask

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
  endfunction

  task automatic send_text(input string s);
    frame_bytes.delete();
    add_text(s);
    send_frame(1'b0);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_display(input logic [pgm_pkg::DISP_W-1:0] w,
                             input logic [pgm_pkg::DISP_W-1:0] h);
    cfg_we <= 1'b1;
    cfg_index <= pgm_pkg::CFG_DISPLAY_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= pgm_pkg::CFG_DISPLAY_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] blank_char();
    if ($urandom_range(0, 1)) return " ";
    return 8'($urandom_range(CTRL_BLANK_LO, CTRL_BLANK_HI));
  endfunction

  function automatic void add_comment();
    logic [7:0] c;
    frame_bytes.push_back("#");
    repeat ($urandom_range(0, 6)) begin
      c = 8'($urandom_range(0, 255));
      frame_bytes.push_back((c == LINE_FEED) ? LINE_FEED + 8'd1 : c);
    end
    frame_bytes.push_back(LINE_FEED);
  endfunction

  // whitespace and comments between header fields
  function automatic void add_gap(input bit need_blank);
    if (need_blank) frame_bytes.push_back(blank_char());
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 1)) add_comment();
      else frame_bytes.push_back(blank_char());
    end
  endfunction

  function automatic void add_number(input int unsigned v);
    if ($urandom_range(0, 7) == 0) add_text("00");
    add_text($sformatf("%0d", v));
  endfunction

  function automatic void build_frame(input frame_fault_e fault);
    int unsigned w, h, mv, npix;
    logic [7:0] b;
    frame_bytes.delete();
    if (fault == F_NOISE) begin
      repeat ($urandom_range(1, 16)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    w = ($urandom_range(0, 15) == 0) ? COORD_MAX : $urandom_range(1, 12);
    h = ($urandom_range(0, 15) == 0) ? COORD_MAX : $urandom_range(1, 12);
    mv = FULL_MAXVAL;
    case (fault)
      F_WIDTH_ZERO:  w = 0;
      F_WIDTH_BIG:   w = $urandom_range(COORD_MAX + 1, 99999);
      F_HEIGHT_ZERO: h = 0;
      F_HEIGHT_BIG:  h = $urandom_range(COORD_MAX + 1, 99999);
      F_MAXVAL_ZERO: mv = 0;
      F_MAXVAL_ODD: begin
        mv = $urandom_range(1, 99999);
        if (mv == FULL_MAXVAL) mv = FULL_MAXVAL + 1;
      end
      default: ;
    endcase
    b = "P";
    if (fault == F_MAGIC_P) while (b == "P") b = 8'($urandom_range(0, 255));
    frame_bytes.push_back(b);
    b = "5";
    if (fault == F_MAGIC_5) while (b == "5") b = 8'($urandom_range(0, 255));
    frame_bytes.push_back(b);
    add_gap(1'b0);
    add_number(w);
    if (fault == F_HASH_IN_NUMBER) frame_bytes.push_back("#");
    if (fault == F_BAD_CHAR) begin
      b = "#";
      while ((b >= "0" && b <= "9") || b == " " || b == "#" ||
             (b >= CTRL_BLANK_LO && b <= CTRL_BLANK_HI))
        b = 8'($urandom_range(0, 255));
      frame_bytes.push_back(b);
    end
    add_gap(1'b1);
    add_number(h);
    add_gap(1'b1);
    add_number(mv);
    frame_bytes.push_back(blank_char());
    // pixel data never ends by itself: overrun the image now and then
    if (fault == F_NONE) npix = $urandom_range(0, (w * h + w < 40) ? w * h + w : 40);
    else npix = $urandom_range(0, 3);
    repeat (npix) frame_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  initial begin : stim
    int target;
    frame_fault_e fault;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // comment right after magic, digits right after the comment, width 3 wraps
    frame_bytes.delete();
    add_text("P5#\n3 1\t255\f");
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(8'hFF);
    frame_bytes.push_back(8'hA0);
    frame_bytes.push_back(8'h1F);
    send_frame(1'b0);
    send_text("QP5");   // bad first magic byte, later bytes ignored
    send_text("P6");
    send_text("P51#");  // '#' right after a digit

    for (int p = 0; p < SETTING_PHASES; p++) begin
      wait_idle();
      case (p)
        0: set_display(DISP_BITS'(1), DISP_BITS'(1));
        1: begin
          set_display(DISP_BITS'(COORD_MAX), DISP_BITS'(COORD_MAX));
          hold_left = LONG_HOLD;
        end
        2: begin
          set_display(DISP_BITS'($urandom_range(1, 16)), DISP_BITS'($urandom_range(1, 16)));
          src_gaps = 1'b0;
          sink_stalls = 1'b0;
        end
        default: begin
          set_display(DISP_BITS'($urandom_range(1, 16)), DISP_BITS'($urandom_range(1, 16)));
          src_gaps = 1'b1;
          sink_stalls = 1'b1;
        end
      endcase
      target = items_done + ITEM_TARGET / SETTING_PHASES;
      while (items_done < target) begin
        fault = ($urandom_range(0, 99) < 70) ? F_NONE :
                frame_fault_e'($urandom_range(F_MAGIC_P, F_NOISE));
        build_frame(fault);
        send_frame(fault == F_NOISE);
        items_done += frame_bytes.size();
      end
    end

    // one-column image: every pixel byte moves to the next row, past the height
    wait_idle();
    set_display(DISP_BITS'(2), DISP_BITS'(COORD_MAX));
    frame_bytes.delete();
    add_text("P5 1 1 255\n");
    repeat (COLUMN_ROWS) frame_bytes.push_back(8'($urandom_range(0, 255)));
    send_frame(1'b0);
    wait_idle();

    if (mismatches == 0 && pending == 0)
      $display("pgm_p5_stream_to_pixels_top verification clean");
    else
      $display("pgm_p5_stream_to_pixels_top verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/pgm_pkg.sv
hw/rtl/pgm_core.sv
hw/rtl/pgm_p5_stream_to_pixels_top.sv
tb/pgm_pixel_checker.sv
tb/tb_pgm_p5_stream_to_pixels_top.sv
